[rtl/pyg_pkg.sv]
// Package for the packed YUV group to RGB converter.
// Types, widths and fixed-point constants shared by the top level and the pixel datapath.
// No dependencies.
package pyg_pkg;

    localparam int PIX_N   = 4;
    localparam int PIX_W   = 8;
    localparam int OFF_W   = 9;
    localparam int SUM_W   = 10;
    localparam int PROD_W  = 24;
    localparam int GSUM_W  = 26;
    localparam int RPRD_W  = 12;

    // chroma offsets: (n * 8192 * K) >> 16 == (n * K) >> 3
    localparam logic signed [RPRD_W-1:0] K_RED  = 12'sd179;
    localparam logic signed [RPRD_W-1:0] K_BLUE = 12'sd228;
    // green: ((n * 8192 * K) >> 8) * C == n * 32 * K * C, exact
    localparam logic signed [GSUM_W-1:0] K_GR = GSUM_W'(32 * 179 * 131);
    localparam logic signed [GSUM_W-1:0] K_GB = GSUM_W'(32 * 228 * 49);

    // luminance weights, Q16
    localparam logic [PROD_W-1:0] W_RED   = 24'd19595;
    localparam logic [PROD_W-1:0] W_GREEN = 24'd38470;
    localparam logic [PROD_W-1:0] W_BLUE  = 24'd7471;
    localparam logic [PROD_W-1:0] W_ROUND = 24'd32768;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

[rtl/pyg_pixel.sv]
// Per-pixel datapath of the packed YUV group converter: add and clamp,
// luminance products, final select. Stages two to four. Depends on pyg_pkg.
module pyg_pixel
    import pyg_pkg::*;
(
    input  logic                    i_clk,
    input  t_stage_en               i_en,
    input  logic                    i_grey,
    input  logic [PIX_W-1:0]        i_luma,
    input  logic signed [OFF_W-1:0] i_roff,
    input  logic signed [OFF_W-1:0] i_goff,
    input  logic signed [OFF_W-1:0] i_boff,
    output logic [PIX_W-1:0]        o_red,
    output logic [PIX_W-1:0]        o_green,
    output logic [PIX_W-1:0]        o_blue
);

    function automatic logic [PIX_W-1:0] clamp8(input logic [PIX_W-1:0] luma,
                                                input logic signed [OFF_W-1:0] off);
        logic signed [SUM_W-1:0] s;
        s = $signed({2'b00, luma}) + SUM_W'(off);
        if (s[SUM_W-1]) begin
            return '0;
        end else if (s[PIX_W]) begin
            return '1;
        end else begin
            return s[PIX_W-1:0];
        end
    endfunction

    logic [PIX_W-1:0]  r_r2, r_g2, r_b2;
    logic [PIX_W-1:0]  r_r3, r_g3, r_b3;
    logic [PROD_W-1:0] r_pr, r_pg, r_pb;
    logic [PROD_W-1:0] w_ysum;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_r2 <= clamp8(i_luma, i_roff);
            r_g2 <= clamp8(i_luma, i_goff);
            r_b2 <= clamp8(i_luma, i_boff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_r3 <= r_r2;
            r_g3 <= r_g2;
            r_b3 <= r_b2;
            r_pr <= PROD_W'(r_r2) * W_RED;
            r_pg <= PROD_W'(r_g2) * W_GREEN;
            r_pb <= PROD_W'(r_b2) * W_BLUE;
        end
    end

    assign w_ysum = r_pr + r_pg + r_pb + W_ROUND;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            if (i_grey) begin
                o_red   <= w_ysum[PROD_W-1:PROD_W-PIX_W];
                o_green <= '0;
                o_blue  <= '0;
            end else begin
                o_red   <= r_r3;
                o_green <= r_g3;
                o_blue  <= r_b3;
            end
        end
    end

endmodule

[rtl/packed_yuv_group_to_rgb.sv]
// Top level of the packed YUV group to RGB converter: input stage, chroma
// offsets, pipeline control, four pixel datapaths. Depends on pyg_pkg, pyg_pixel.
//
// Input channel: i_valid / o_stall with four packed bytes; a beat is taken
// when i_valid is high and o_stall is low. Output channel: o_valid / i_stall
// with red, green and blue of four pixels; a beat leaves when o_valid is high
// and i_stall is low.
// Four register stages: chroma offsets and luma, add and clamp, luminance
// products, output select; a group passes through them in that order. One
// group per cycle is sustained while the output is not stalled.
// Each stage holds its beat when the next one is full and stalled; empty
// stages keep filling, so up to four groups wait inside during a stall and
// nothing is lost or repeated.
// i_cfg_wr_en writes i_cfg_wr_data into grey mode (write only while idle):
// red then carries the rounded luminance, green and blue read zero.
// Synchronous active-low reset empties the pipeline and clears grey mode.
module packed_yuv_group_to_rgb
    import pyg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_byte_zero,
    input  logic [PIX_W-1:0] i_byte_one,
    input  logic [PIX_W-1:0] i_byte_two,
    input  logic [PIX_W-1:0] i_byte_three,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_red_zero,
    output logic [PIX_W-1:0] o_red_one,
    output logic [PIX_W-1:0] o_red_two,
    output logic [PIX_W-1:0] o_red_three,
    output logic [PIX_W-1:0] o_green_zero,
    output logic [PIX_W-1:0] o_green_one,
    output logic [PIX_W-1:0] o_green_two,
    output logic [PIX_W-1:0] o_green_three,
    output logic [PIX_W-1:0] o_blue_zero,
    output logic [PIX_W-1:0] o_blue_one,
    output logic [PIX_W-1:0] o_blue_two,
    output logic [PIX_W-1:0] o_blue_three
);

    logic                    r_grey;
    logic [4:1]              r_vld;
    logic [4:1]              n_vld;
    logic [4:1]              w_rdy;
    t_stage_en               w_en;

    logic [PIX_W-1:0]        w_byte [PIX_N];
    logic signed [3:0]       w_rn, w_bn;
    logic signed [RPRD_W-1:0] w_rprd, w_bprd;
    logic signed [GSUM_W-1:0] w_gsum;

    logic [PIX_W-1:0]        r_luma [PIX_N];
    logic signed [OFF_W-1:0] r_roff, r_goff, r_boff;

    logic [PIX_W-1:0]        w_red   [PIX_N];
    logic [PIX_W-1:0]        w_green [PIX_N];
    logic [PIX_W-1:0]        w_blue  [PIX_N];

    // stage readiness, back from the output
    assign w_rdy[4] = !r_vld[4] || !i_stall;
    assign w_rdy[3] = !r_vld[3] || w_rdy[4];
    assign w_rdy[2] = !r_vld[2] || w_rdy[3];
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign o_stall  = !w_rdy[1];
    assign o_valid  = r_vld[4];

    assign w_en.s2 = w_rdy[2];
    assign w_en.s3 = w_rdy[3];
    assign w_en.s4 = w_rdy[4];

    always_comb begin
        n_vld[1] = w_rdy[1] ? i_valid  : r_vld[1];
        n_vld[2] = w_rdy[2] ? r_vld[1] : r_vld[2];
        n_vld[3] = w_rdy[3] ? r_vld[2] : r_vld[3];
        n_vld[4] = w_rdy[4] ? r_vld[3] : r_vld[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_grey <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_wr_en) begin
                r_grey <= i_cfg_wr_data;
            end
        end
    end

    assign w_byte[0] = i_byte_zero;
    assign w_byte[1] = i_byte_one;
    assign w_byte[2] = i_byte_two;
    assign w_byte[3] = i_byte_three;

    // nibble - 8 is the nibble with its top bit flipped, as 4-bit signed
    assign w_rn = {~w_byte[0][7], w_byte[0][6], w_byte[1][7:6]};
    assign w_bn = {~w_byte[2][7], w_byte[2][6], w_byte[3][7:6]};

    assign w_rprd = RPRD_W'(w_rn) * K_RED;
    assign w_bprd = RPRD_W'(w_bn) * K_BLUE;
    assign w_gsum = -(GSUM_W'(w_rn) * K_GR) - (GSUM_W'(w_bn) * K_GB);

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_roff <= w_rprd[OFF_W+2:3];
            r_boff <= w_bprd[OFF_W+2:3];
            r_goff <= w_gsum[OFF_W+15:16];
            for (int k = 0; k < PIX_N; k++) begin
                r_luma[k] <= {w_byte[k][5:1], 3'b000};
            end
        end
    end

    for (genvar g = 0; g < PIX_N; g++) begin : g_pix
        pyg_pixel u_pixel (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_grey  (r_grey),
            .i_luma  (r_luma[g]),
            .i_roff  (r_roff),
            .i_goff  (r_goff),
            .i_boff  (r_boff),
            .o_red   (w_red[g]),
            .o_green (w_green[g]),
            .o_blue  (w_blue[g])
        );
    end

    assign o_red_zero    = w_red[0];
    assign o_red_one     = w_red[1];
    assign o_red_two     = w_red[2];
    assign o_red_three   = w_red[3];
    assign o_green_zero  = w_green[0];
    assign o_green_one   = w_green[1];
    assign o_green_two   = w_green[2];
    assign o_green_three = w_green[3];
    assign o_blue_zero   = w_blue[0];
    assign o_blue_one    = w_blue[1];
    assign o_blue_two    = w_blue[2];
    assign o_blue_three  = w_blue[3];

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat valid right after reset");

    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_grey) |-> (o_green_zero == '0 && o_green_one == '0 &&
        o_green_two == '0 && o_green_three == '0 && o_blue_zero == '0 &&
        o_blue_one == '0 && o_blue_two == '0 && o_blue_three == '0))
        else $error("green or blue nonzero in grey mode");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled output beat dropped");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[1])
        else $error("accepted input beat not captured");

endmodule
